[rtl/alhc_pkg.sv]
package alhc_pkg;

	localparam int TIMER_BITS_DEF = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [2:0] {
		LV_AP    = 3'd0,
		LV_CONN  = 3'd1,
		LV_OK    = 3'd2,
		LV_PRE   = 3'd3,
		LV_ALERT = 3'd4
	} level_t;

	typedef enum logic [2:0] {
		FN_TICK      = 3'd0,
		FN_REALTIME  = 3'd1,
		FN_HIST_REC  = 3'd2,
		FN_HIST_BEG  = 3'd3,
		FN_TEST      = 3'd4,
		FN_LINK_UP   = 3'd5,
		FN_LINK_DOWN = 3'd6,
		FN_AP_MODE   = 3'd7
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRE_HOLD  = 3'd0,
		REG_ALERT_HOLD = 3'd1,
		REG_IDLE_THR  = 3'd2,
		REG_POLL_ACT  = 3'd3,
		REG_POLL_IDLE = 3'd4,
		REG_TEST_STEP = 3'd5,
		REG_BLINK_HALF = 3'd6
	} cfg_reg_t;

	localparam logic [7:0] CAT_PRE     = 8'd14;
	localparam logic [7:0] CAT_END     = 8'd13;
	localparam logic [7:0] CAT_RT_SKIP = 8'd10;

	localparam logic [23:0] RGB_OFF    = 24'h000000;
	localparam logic [23:0] RGB_BLUE   = 24'h0000FF;
	localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
	localparam logic [23:0] RGB_ORANGE = 24'hFF8C00;
	localparam logic [23:0] RGB_RED    = 24'hFF0000;

	localparam logic [9:0]  BLINK_MAX  = 10'd1023;
	localparam logic [12:0] TEST_MAX   = 13'd8191;
	localparam logic [9:0]  MS_PER_S   = 10'd1000;

	localparam logic [13:0] PRE_HOLD_RST   = 14'd1200;
	localparam logic [13:0] ALERT_HOLD_RST = 14'd10800;
	localparam logic [23:0] IDLE_THR_RST   = 24'd600000;
	localparam logic [15:0] POLL_ACT_RST   = 16'd2000;
	localparam logic [15:0] POLL_IDLE_RST  = 16'd20000;
	localparam logic [10:0] TEST_STEP_RST  = 11'd1500;
	localparam logic [9:0]  BLINK_HALF_RST = 10'd500;

	typedef struct packed {
		logic [13:0] pre_alert_hold_s;
		logic [13:0] alert_hold_s;
		logic [23:0] idle_limit_ms;
		logic [15:0] fast_poll_ms;
		logic [15:0] slow_poll_ms;
		logic [10:0] test_step_ms;
		logic [9:0]  blink_half_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  device_state;
		logic [23:0] lamp_color;
		logic [15:0] poll_interval_ms;
		logic        test_busy;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] cat;
	} rt_map_t;

	function automatic logic is_alert_cat(input logic [7:0] c);
		logic r;
		case (c) inside
			8'd1, 8'd2, 8'd3, 8'd4, [8'd7:8'd12]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic rt_map_t rt_map(input logic [7:0] c);
		rt_map_t r;
		r.hit = 1'b1;
		case (c)
			8'd1:    r.cat = 8'd1;
			8'd3:    r.cat = 8'd7;
			8'd4:    r.cat = 8'd9;
			8'd5:    r.cat = 8'd11;
			8'd6:    r.cat = 8'd2;
			8'd7:    r.cat = 8'd12;
			8'd13:   r.cat = 8'd10;
			default: begin
				r.hit = 1'b0;
				r.cat = 8'd0;
			end
		endcase
		return r;
	endfunction

endpackage

[rtl/alhc_cfg_regs.sv]
module alhc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [alhc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [alhc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output alhc_pkg::cfg_t                     cfg
);

	alhc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_alert_hold_s <= alhc_pkg::PRE_HOLD_RST;
			cfg_q.alert_hold_s     <= alhc_pkg::ALERT_HOLD_RST;
			cfg_q.idle_limit_ms    <= alhc_pkg::IDLE_THR_RST;
			cfg_q.fast_poll_ms     <= alhc_pkg::POLL_ACT_RST;
			cfg_q.slow_poll_ms     <= alhc_pkg::POLL_IDLE_RST;
			cfg_q.test_step_ms     <= alhc_pkg::TEST_STEP_RST;
			cfg_q.blink_half_ms    <= alhc_pkg::BLINK_HALF_RST;
		end else if (cfg_wen) begin
			unique case (alhc_pkg::cfg_reg_t'(cfg_idx))
				alhc_pkg::REG_PRE_HOLD:   cfg_q.pre_alert_hold_s <= cfg_data[13:0];
				alhc_pkg::REG_ALERT_HOLD: cfg_q.alert_hold_s     <= cfg_data[13:0];
				alhc_pkg::REG_IDLE_THR:   cfg_q.idle_limit_ms    <= cfg_data[23:0];
				alhc_pkg::REG_POLL_ACT:   cfg_q.fast_poll_ms     <= cfg_data[15:0];
				alhc_pkg::REG_POLL_IDLE:  cfg_q.slow_poll_ms     <= cfg_data[15:0];
				alhc_pkg::REG_TEST_STEP:  cfg_q.test_step_ms     <= cfg_data[10:0];
				alhc_pkg::REG_BLINK_HALF: cfg_q.blink_half_ms    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/alhc_core.sv]
module alhc_core #(
	parameter int TIMER_BITS = alhc_pkg::TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  alhc_pkg::cfg_t       cfg,
	input  logic [2:0]           func,
	input  logic [7:0]           category,
	input  logic [31:0]          record_age_s,
	input  logic                 clock_valid,
	output alhc_pkg::result_t    result
);

	localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;

	alhc_pkg::level_t        lvl_q, lvl_d;
	logic [TIMER_BITS-1:0]   lvl_el_q, lvl_el_d, lvl_el_inc;
	logic [TIMER_BITS-1:0]   since_q, since_d;
	logic                    test_q, test_d;
	logic [12:0]             test_el_q, test_el_d;
	logic [9:0]              blink_cnt_q, blink_cnt_d;
	logic                    blink_ph_q, blink_ph_d;
	logic                    applied_q, applied_d;

	logic                    do_raise;
	alhc_pkg::level_t        raise_lv;
	logic [13:0]             hold_s;
	logic [23:0]             hold_ms;
	alhc_pkg::rt_map_t       rt;
	logic [12:0]             step1, step2, step3;
	logic [23:0]             color;
	logic [15:0]             poll;

	always_comb begin
		lvl_d       = lvl_q;
		lvl_el_d    = lvl_el_q;
		since_d     = since_q;
		test_d      = test_q;
		test_el_d   = test_el_q;
		blink_cnt_d = blink_cnt_q;
		blink_ph_d  = blink_ph_q;
		applied_d   = applied_q;
		do_raise    = 1'b0;
		raise_lv    = alhc_pkg::LV_ALERT;

		lvl_el_inc = (lvl_el_q == '1) ? lvl_el_q : lvl_el_q + TIMER_BITS'(1);
		hold_s     = (lvl_q == alhc_pkg::LV_PRE) ? cfg.pre_alert_hold_s : cfg.alert_hold_s;
		hold_ms    = {10'd0, hold_s} * {14'd0, alhc_pkg::MS_PER_S};
		rt         = alhc_pkg::rt_map(category);

		unique case (alhc_pkg::func_t'(func))
			alhc_pkg::FN_TICK: begin
				lvl_el_d    = lvl_el_inc;
				since_d     = (since_q == '1) ? since_q : since_q + TIMER_BITS'(1);
				blink_cnt_d = (blink_cnt_q == alhc_pkg::BLINK_MAX) ? blink_cnt_q
				              : blink_cnt_q + 10'd1;
				if (test_q && test_el_q != alhc_pkg::TEST_MAX) begin
					test_el_d = test_el_q + 13'd1;
				end
				if ((lvl_q == alhc_pkg::LV_PRE || lvl_q == alhc_pkg::LV_ALERT) &&
				    ((lvl_el_inc == '1) || (CW'(lvl_el_inc) >= CW'(hold_ms)))) begin
					lvl_d = alhc_pkg::LV_OK;
				end
			end
			alhc_pkg::FN_REALTIME: begin
				if (category != alhc_pkg::CAT_RT_SKIP && rt.hit &&
				    alhc_pkg::is_alert_cat(rt.cat)) begin
					do_raise = 1'b1;
					raise_lv = alhc_pkg::LV_ALERT;
				end
			end
			alhc_pkg::FN_HIST_REC: begin
				if (!applied_q) begin
					applied_d = 1'b1;
					if (category == alhc_pkg::CAT_END) begin
						lvl_d = alhc_pkg::LV_OK;
					end else if (category == alhc_pkg::CAT_PRE) begin
						if (clock_valid && record_age_s <= {18'd0, cfg.pre_alert_hold_s}) begin
							do_raise = 1'b1;
							raise_lv = alhc_pkg::LV_PRE;
						end
					end else if (alhc_pkg::is_alert_cat(category)) begin
						if (clock_valid && record_age_s <= {18'd0, cfg.alert_hold_s}) begin
							do_raise = 1'b1;
							raise_lv = alhc_pkg::LV_ALERT;
						end
					end
				end
			end
			alhc_pkg::FN_HIST_BEG:  applied_d = 1'b0;
			alhc_pkg::FN_TEST: begin
				test_d    = 1'b1;
				test_el_d = 13'd0;
			end
			alhc_pkg::FN_LINK_UP:   lvl_d = alhc_pkg::LV_OK;
			alhc_pkg::FN_LINK_DOWN: lvl_d = alhc_pkg::LV_CONN;
			default:                lvl_d = alhc_pkg::LV_AP;
		endcase

		// pre-alert never overrides alert
		if (do_raise && !(raise_lv == alhc_pkg::LV_PRE && lvl_q == alhc_pkg::LV_ALERT)) begin
			lvl_d    = raise_lv;
			lvl_el_d = '0;
			since_d  = '0;
		end

		step1 = {2'd0, cfg.test_step_ms};
		step2 = {1'b0, cfg.test_step_ms, 1'b0};
		step3 = step2 + step1;

		if (test_d) begin
			if (test_el_d < step1) begin
				color = alhc_pkg::RGB_GREEN;
			end else if (test_el_d < step2) begin
				color = alhc_pkg::RGB_ORANGE;
			end else if (test_el_d < step3) begin
				color = alhc_pkg::RGB_RED;
			end else begin
				test_d = 1'b0;
				color  = alhc_pkg::RGB_GREEN;
			end
		end else begin
			case (lvl_d)
				alhc_pkg::LV_AP:  color = alhc_pkg::RGB_BLUE;
				alhc_pkg::LV_CONN: begin
					if (blink_cnt_d >= cfg.blink_half_ms) begin
						blink_cnt_d = 10'd0;
						blink_ph_d  = ~blink_ph_d;
					end
					color = blink_ph_d ? alhc_pkg::RGB_BLUE : alhc_pkg::RGB_OFF;
				end
				alhc_pkg::LV_OK:  color = alhc_pkg::RGB_GREEN;
				alhc_pkg::LV_PRE: color = alhc_pkg::RGB_ORANGE;
				default:          color = alhc_pkg::RGB_RED;
			endcase
		end

		if (lvl_d == alhc_pkg::LV_PRE || lvl_d == alhc_pkg::LV_ALERT ||
		    CW'(since_d) < CW'(cfg.idle_limit_ms)) begin
			poll = cfg.fast_poll_ms;
		end else begin
			poll = cfg.slow_poll_ms;
		end

		result.device_state     = lvl_d;
		result.lamp_color       = color;
		result.poll_interval_ms = poll;
		result.test_busy        = test_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q       <= alhc_pkg::LV_AP;
			lvl_el_q    <= '0;
			since_q     <= '0;
			test_q      <= 1'b0;
			test_el_q   <= 13'd0;
			blink_cnt_q <= 10'd0;
			blink_ph_q  <= 1'b0;
			applied_q   <= 1'b0;
		end else if (fire) begin
			lvl_q       <= lvl_d;
			lvl_el_q    <= lvl_el_d;
			since_q     <= since_d;
			test_q      <= test_d;
			test_el_q   <= test_el_d;
			blink_cnt_q <= blink_cnt_d;
			blink_ph_q  <= blink_ph_d;
			applied_q   <= applied_d;
		end
	end

endmodule

[rtl/alert_level_hold_controller.sv]
// An accepted request is held in the input stage; its result then enters the result
// register, with out_valid high, once that stage is free to take it.
// Throughput: one request per cycle while out_ready is high; the result register frees as it is taken.
// Reset (arst_n low): level AP, all timers and flags zero, registers at their
// default values, both stages empty.
module alert_level_hold_controller #(
	parameter int TIMER_BITS = alhc_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       func,
	input  logic [7:0]                       category,
	input  logic [31:0]                      record_age_s,
	input  logic                             clock_valid,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       device_state,
	output logic [23:0]                      lamp_color,
	output logic [15:0]                      poll_interval_ms,
	output logic                             test_busy,
	input  logic                             cfg_wen,
	input  logic [alhc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [alhc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	alhc_pkg::cfg_t     cfg;
	alhc_pkg::result_t  result;
	alhc_pkg::result_t  res_s2;

	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [7:0]  category_s1;
	logic [31:0] age_s1;
	logic        clkv_s1;
	logic        valid_s2;
	logic        advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	alhc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	alhc_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.cfg          (cfg),
		.func         (func_s1),
		.category     (category_s1),
		.record_age_s (age_s1),
		.clock_valid  (clkv_s1),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1     <= func;
			category_s1 <= category;
			age_s1      <= record_age_s;
			clkv_s1     <= clock_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid        = valid_s2;
	assign device_state     = res_s2.device_state;
	assign lamp_color       = res_s2.lamp_color;
	assign poll_interval_ms = res_s2.poll_interval_ms;
	assign test_busy        = res_s2.test_busy;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result stage");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced request produced no result");

	a_test_colors: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.test_busy) |->
		(res_s2.lamp_color == alhc_pkg::RGB_GREEN ||
		 res_s2.lamp_color == alhc_pkg::RGB_ORANGE ||
		 res_s2.lamp_color == alhc_pkg::RGB_RED))
		else $error("lamp test shows a color outside its sequence");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam logic [23:0] LEVEL_MS_MAX = '1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  func = alhc_pkg::FN_TICK;
	logic [7:0]  category = '0;
	logic [31:0] record_age_s = '0;
	logic        clock_valid = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  device_state;
	logic [23:0] lamp_color;
	logic [15:0] poll_interval_ms;
	logic        test_busy;
	logic        cfg_wen = 1'b0;
	logic [alhc_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [alhc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	alert_level_hold_controller dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.category         (category),
		.record_age_s     (record_age_s),
		.clock_valid      (clock_valid),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.device_state     (device_state),
		.lamp_color       (lamp_color),
		.poll_interval_ms (poll_interval_ms),
		.test_busy        (test_busy),
		.cfg_wen          (cfg_wen),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// device status model
	logic [23:0] cfg_val [7] = '{24'(alhc_pkg::PRE_HOLD_RST), 24'(alhc_pkg::ALERT_HOLD_RST),
		alhc_pkg::IDLE_THR_RST, 24'(alhc_pkg::POLL_ACT_RST), 24'(alhc_pkg::POLL_IDLE_RST),
		24'(alhc_pkg::TEST_STEP_RST), 24'(alhc_pkg::BLINK_HALF_RST)};
	alhc_pkg::level_t dev_level = alhc_pkg::LV_AP;
	logic [23:0] level_ms = '0;
	logic [23:0] quiet_ms = '0;
	logic        test_on = 1'b0;
	logic [12:0] test_ms = '0;
	logic [9:0]  blink_ms = '0;
	logic        blink_on = 1'b0;
	logic        record_taken = 1'b0;

	alhc_pkg::result_t status_queue [$];
	int      mismatch_count = 0;
	int      events_sent = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	logic [7:0] alert_codes [10] = '{1, 2, 3, 4, 7, 8, 9, 10, 11, 12};
	logic [7:0] realtime_codes [8] = '{1, 3, 4, 5, 6, 7, 13, alhc_pkg::CAT_RT_SKIP};

	function automatic logic [23:0] reg_mask(input alhc_pkg::cfg_reg_t r);
		case (r)
			alhc_pkg::REG_PRE_HOLD, alhc_pkg::REG_ALERT_HOLD: return 24'h003FFF;
			alhc_pkg::REG_IDLE_THR: return 24'hFFFFFF;
			alhc_pkg::REG_POLL_ACT, alhc_pkg::REG_POLL_IDLE: return 24'h00FFFF;
			alhc_pkg::REG_TEST_STEP: return 24'h0007FF;
			default: return 24'h0003FF;
		endcase
	endfunction

	function automatic logic realtime_gives_alert(input logic [7:0] c);
		case (c)
			8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd13: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void raise_level_to(input alhc_pkg::level_t target);
		if (target == alhc_pkg::LV_PRE && dev_level == alhc_pkg::LV_ALERT)
			return;
		dev_level = target;
		level_ms = '0;
		quiet_ms = '0;
	endfunction

	function automatic logic [23:0] lamp_for_state();
		int unsigned step;
		step = cfg_val[alhc_pkg::REG_TEST_STEP];
		if (test_on) begin
			if (test_ms < step)
				return alhc_pkg::RGB_GREEN;
			if (test_ms < 2 * step)
				return alhc_pkg::RGB_ORANGE;
			if (test_ms < 3 * step)
				return alhc_pkg::RGB_RED;
			test_on = 1'b0;
			return alhc_pkg::RGB_GREEN;
		end
		case (dev_level)
			alhc_pkg::LV_AP: return alhc_pkg::RGB_BLUE;
			alhc_pkg::LV_CONN: begin
				if (blink_ms >= cfg_val[alhc_pkg::REG_BLINK_HALF][9:0]) begin
					blink_ms = '0;
					blink_on = !blink_on;
				end
				return blink_on ? alhc_pkg::RGB_BLUE : alhc_pkg::RGB_OFF;
			end
			alhc_pkg::LV_OK: return alhc_pkg::RGB_GREEN;
			alhc_pkg::LV_PRE: return alhc_pkg::RGB_ORANGE;
			default: return alhc_pkg::RGB_RED;
		endcase
	endfunction

	function automatic alhc_pkg::result_t predict_status(input alhc_pkg::func_t f,
			input logic [7:0] c, input logic [31:0] age, input logic cv);
		alhc_pkg::result_t r;
		logic [31:0] hold_ms;
		case (f)
			alhc_pkg::FN_TICK: begin
				if (level_ms != LEVEL_MS_MAX)
					level_ms = level_ms + 24'd1;
				if (quiet_ms != LEVEL_MS_MAX)
					quiet_ms = quiet_ms + 24'd1;
				if (blink_ms != alhc_pkg::BLINK_MAX)
					blink_ms = blink_ms + 10'd1;
				if (test_on && test_ms != alhc_pkg::TEST_MAX)
					test_ms = test_ms + 13'd1;
				if (dev_level == alhc_pkg::LV_PRE || dev_level == alhc_pkg::LV_ALERT) begin
					hold_ms = 32'(dev_level == alhc_pkg::LV_PRE ?
						cfg_val[alhc_pkg::REG_PRE_HOLD] :
						cfg_val[alhc_pkg::REG_ALERT_HOLD]) * 32'd1000;
					if (hold_ms > 32'(LEVEL_MS_MAX))
						hold_ms = 32'(LEVEL_MS_MAX);
					if (32'(level_ms) >= hold_ms)
						dev_level = alhc_pkg::LV_OK;
				end
			end
			alhc_pkg::FN_REALTIME: begin
				if (realtime_gives_alert(c))
					raise_level_to(alhc_pkg::LV_ALERT);
			end
			alhc_pkg::FN_HIST_REC: begin
				if (!record_taken) begin
					record_taken = 1'b1;
					if (c == alhc_pkg::CAT_END)
						dev_level = alhc_pkg::LV_OK;
					else if (c == alhc_pkg::CAT_PRE) begin
						if (cv && age <= 32'(cfg_val[alhc_pkg::REG_PRE_HOLD]))
							raise_level_to(alhc_pkg::LV_PRE);
					end else if (c inside {[8'd1:8'd4], [8'd7:8'd12]}) begin
						if (cv && age <= 32'(cfg_val[alhc_pkg::REG_ALERT_HOLD]))
							raise_level_to(alhc_pkg::LV_ALERT);
					end
				end
			end
			alhc_pkg::FN_HIST_BEG: record_taken = 1'b0;
			alhc_pkg::FN_TEST: begin
				test_on = 1'b1;
				test_ms = '0;
			end
			alhc_pkg::FN_LINK_UP: dev_level = alhc_pkg::LV_OK;
			alhc_pkg::FN_LINK_DOWN: dev_level = alhc_pkg::LV_CONN;
			default: dev_level = alhc_pkg::LV_AP;
		endcase
		r.lamp_color = lamp_for_state();
		r.device_state = dev_level;
		if (dev_level == alhc_pkg::LV_PRE || dev_level == alhc_pkg::LV_ALERT ||
				quiet_ms < cfg_val[alhc_pkg::REG_IDLE_THR])
			r.poll_interval_ms = cfg_val[alhc_pkg::REG_POLL_ACT][15:0];
		else
			r.poll_interval_ms = cfg_val[alhc_pkg::REG_POLL_IDLE][15:0];
		r.test_busy = test_on;
		return r;
	endfunction

	always @(posedge clk) begin
		alhc_pkg::result_t want;
		if (out_valid && out_ready) begin
			if (status_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("mismatch: result with no request pending, state %0d lamp %06h",
						device_state, lamp_color);
			end else begin
				want = status_queue.pop_front();
				if (device_state !== want.device_state || lamp_color !== want.lamp_color ||
						poll_interval_ms !== want.poll_interval_ms ||
						test_busy !== want.test_busy) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected state %0d lamp %06h poll %0d busy %0b, %s",
							want.device_state, want.lamp_color, want.poll_interval_ms,
							want.test_busy, $sformatf("got state %0d lamp %06h poll %0d busy %0b",
							device_state, lamp_color, poll_interval_ms, test_busy));
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_event(input alhc_pkg::func_t f, input logic [7:0] c,
			input logic [31:0] age, input logic cv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		category <= c;
		record_age_s <= age;
		clock_valid <= cv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		status_queue.push_back(predict_status(f, c, age, cv));
		events_sent++;
	endtask

	task automatic send_record(input logic [7:0] c, input logic [31:0] age, input logic cv);
		send_event(alhc_pkg::FN_HIST_BEG, $urandom, $urandom, $urandom);
		send_event(alhc_pkg::FN_HIST_REC, c, age, cv);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (status_queue.size() != 0);
	endtask

	task automatic write_setting(input logic [23:0] pre_s, input logic [23:0] alert_s,
			input logic [23:0] idle_ms, input logic [23:0] act_ms, input logic [23:0] slow_ms,
			input logic [23:0] step_ms, input logic [23:0] half_ms);
		logic [23:0] v [7];
		logic [23:0] data;
		alhc_pkg::cfg_reg_t r;
		int i;
		v = '{pre_s, alert_s, idle_ms, act_ms, slow_ms, step_ms, half_ms};
		wait_for_results();
		for (i = 0; i < 7; i++) begin
			r = alhc_pkg::cfg_reg_t'(i);
			data = v[i];
			if ($urandom_range(1))
				data = data | (24'($urandom) & ~reg_mask(r));
			cfg_wen <= 1'b1;
			cfg_idx <= r;
			cfg_data <= data;
			@(posedge clk);
			cfg_val[r] = data & reg_mask(r);
		end
		cfg_wen <= 1'b0;
	endtask

	task automatic send_random_record();
		logic [7:0] c;
		logic [31:0] hold;
		logic [31:0] age;
		int pick;
		pick = $urandom_range(99);
		if (pick < 20)
			c = alhc_pkg::CAT_END;
		else if (pick < 45)
			c = alhc_pkg::CAT_PRE;
		else if (pick < 85)
			c = alert_codes[$urandom_range(9)];
		else
			c = 8'($urandom);
		hold = 32'((c == alhc_pkg::CAT_PRE) ? cfg_val[alhc_pkg::REG_PRE_HOLD] :
			cfg_val[alhc_pkg::REG_ALERT_HOLD]);
		case ($urandom_range(6))
			0: age = '0;
			1: age = hold;
			2: age = hold + 32'd1;
			3: age = hold - 32'd1;
			4: age = $urandom_range(2 * hold + 2);
			5: age = $urandom;
			default: age = '1;
		endcase
		send_event(alhc_pkg::FN_HIST_REC, c, age, $urandom_range(99) < 85);
	endtask

	task automatic random_activity(input int count);
		int stop_at;
		int pick;
		int n;
		int i;
		stop_at = events_sent + count;
		while (events_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				n = $urandom_range(30, 1);
				for (i = 0; i < n; i++)
					send_event(alhc_pkg::FN_TICK, $urandom, $urandom, $urandom);
			end else if (pick < 55) begin
				send_event(alhc_pkg::FN_HIST_BEG, $urandom, $urandom, $urandom);
				n = $urandom_range(3, 1);
				for (i = 0; i < n; i++)
					send_random_record();
			end else if (pick < 68) begin
				if ($urandom_range(99) < 70)
					send_event(alhc_pkg::FN_REALTIME, realtime_codes[$urandom_range(7)],
						$urandom, $urandom);
				else
					send_event(alhc_pkg::FN_REALTIME, $urandom, $urandom, $urandom);
			end else if (pick < 75)
				send_event(alhc_pkg::FN_TEST, $urandom, $urandom, $urandom);
			else if (pick < 82)
				send_event(alhc_pkg::FN_LINK_UP, $urandom, $urandom, $urandom);
			else if (pick < 89)
				send_event(alhc_pkg::FN_LINK_DOWN, $urandom, $urandom, $urandom);
			else if (pick < 92)
				send_event(alhc_pkg::FN_AP_MODE, $urandom, $urandom, $urandom);
			else
				send_event(alhc_pkg::func_t'($urandom_range(7)), $urandom, $urandom,
					$urandom);
		end
	endtask

	task automatic test_power_on();
		send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_LINK_DOWN, 8'hFF, 32'hFFFFFFFF, 1'b1);
		send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_LINK_UP, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_AP_MODE, 8'h00, 32'h0, 1'b0);
	endtask

	task automatic test_realtime_map();
		send_event(alhc_pkg::FN_REALTIME, alhc_pkg::CAT_RT_SKIP, 32'h0, 1'b1);
		send_event(alhc_pkg::FN_REALTIME, 8'd2, 32'h0, 1'b1);
		send_event(alhc_pkg::FN_REALTIME, 8'd255, 32'h0, 1'b1);
		send_event(alhc_pkg::FN_REALTIME, 8'd1, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_REALTIME, 8'd13, 32'h0, 1'b0);
	endtask

	task automatic test_history_rules();
		send_event(alhc_pkg::FN_LINK_UP, 8'h00, 32'h0, 1'b0);
		send_record(alhc_pkg::CAT_PRE, 32'd1200, 1'b1);
		send_event(alhc_pkg::FN_HIST_REC, 8'd1, 32'h0, 1'b1);
		send_record(8'd1, 32'd10800, 1'b1);
		send_record(alhc_pkg::CAT_PRE, 32'h0, 1'b1);
		send_record(alhc_pkg::CAT_END, 32'h0, 1'b0);
		send_record(8'd9, 32'd10801, 1'b1);
		send_record(8'd9, 32'h0, 1'b0);
		send_record(8'd200, 32'h0, 1'b1);
		send_record(alhc_pkg::CAT_PRE, 32'hFFFFFFFF, 1'b1);
	endtask

	task automatic test_lamp_sequence();
		int i;
		write_setting(1200, 10800, 600000, 2000, 20000, 1, 0);
		send_event(alhc_pkg::FN_TEST, 8'h00, 32'h0, 1'b0);
		for (i = 0; i < 4; i++)
			send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_LINK_DOWN, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_REALTIME, alhc_pkg::CAT_RT_SKIP, 32'h0, 1'b0);
		write_setting(1200, 10800, 600000, 2000, 20000, 0, 500);
		send_event(alhc_pkg::FN_TEST, 8'h00, 32'h0, 1'b0);
	endtask

	task automatic test_zero_hold();
		write_setting(0, 0, 0, 2000, 20000, 1500, 500);
		send_event(alhc_pkg::FN_LINK_UP, 8'h00, 32'h0, 1'b0);
		send_record(alhc_pkg::CAT_PRE, 32'd1, 1'b1);
		send_record(alhc_pkg::CAT_PRE, 32'd0, 1'b1);
		send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_REALTIME, 8'd1, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
	endtask

	task automatic test_hold_restart();
		int i;
		write_setting(1, 1, 20, 2000, 20000, 1500, 1023);
		send_event(alhc_pkg::FN_REALTIME, 8'd6, 32'h0, 1'b0);
		for (i = 0; i < 24; i++)
			send_event(alhc_pkg::FN_TICK, $urandom, $urandom, $urandom);
		send_event(alhc_pkg::FN_REALTIME, 8'd6, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_LINK_DOWN, 8'h00, 32'h0, 1'b0);
		send_event(alhc_pkg::FN_TICK, 8'h00, 32'h0, 1'b0);
	endtask

	task automatic test_random_traffic();
		int k;
		int m;
		for (k = 0; k < 5; k++) begin
			case (k)
				0: write_setting(0, 0, 0, 0, 1, 0, 0);
				1: write_setting('1, '1, '1, '1, '1, '1, '1);
				default: write_setting(24'($urandom_range(2)), 24'($urandom_range(2)),
					24'($urandom_range(300)), 24'($urandom_range(65535, 1)),
					24'($urandom_range(65535, 1)), 24'($urandom_range(12, 1)),
					24'($urandom_range(20)));
			endcase
			for (m = 0; m < 4; m++) begin
				case (m)
					0: begin
						send_idle_pct = 0;
						recv_stall_pct = 0;
					end
					1: begin
						send_idle_pct = 67;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct = 0;
						recv_stall_pct = 67;
					end
					default: begin
						send_idle_pct = 12;
						recv_stall_pct = 12;
					end
				endcase
				random_activity(40);
			end
		end
	endtask

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_power_on();
		test_realtime_map();
		test_history_rules();
		test_lamp_sequence();
		test_zero_hold();
		test_hold_restart();
		test_random_traffic();
		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

[files.f]
rtl/alhc_pkg.sv
rtl/alhc_cfg_regs.sv
rtl/alhc_core.sv
rtl/alert_level_hold_controller.sv
bench/tb.sv
